// ----- hdl/rar_pkg.sv -----
// shared types and constants for the rational arithmetic reduce unit
`timescale 1ns / 1ps
package rar_pkg;

	// port widths fixed by the word format
	localparam int IN_W      = 16;
	localparam int CMD_W     = 3;
	localparam int RAW_NUM_W = 33;
	localparam int RAW_DEN_W = 32;

	// significant bits of each input term, sign at TERM_WIDTH-1 (at most IN_W)
	localparam int TERM_WIDTH = 16;
	localparam int PROD_W     = 2 * TERM_WIDTH;
	localparam int WORK_W     = 2 * TERM_WIDTH + 1;
	localparam int CNT_W      = $clog2(WORK_W + 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 3'd0,
		CMD_SUB   = 3'd1,
		CMD_MUL   = 3'd2,
		CMD_DIV   = 3'd3,
		CMD_RECIP = 3'd4
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL0,
		S_MUL1,
		S_MUL2,
		S_COMB,
		S_EUCLID,
		S_EU_WAIT,
		S_QN,
		S_QN_WAIT,
		S_QD,
		S_QD_WAIT,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic                     start;
		logic signed [WORK_W-1:0] dividend;
		logic signed [WORK_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                     done;
		logic signed [WORK_W-1:0] quot;
		logic signed [WORK_W-1:0] rem;
	} div_rsp_t;

endpackage

// ----- hdl/rar_div.sv -----
// iterative signed divider, truncating quotient and remainder, one bit per cycle
`timescale 1ns / 1ps
module rar_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rar_pkg::div_req_t req,
	output rar_pkg::div_rsp_t rsp
);
	import rar_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORK_W-1:0] den_q;
	logic [WORK_W-1:0] quo_q;
	logic [WORK_W-1:0] rem_q;
	logic              qneg_q;
	logic              rneg_q;

	logic [WORK_W-1:0] dvd_mag;
	logic [WORK_W-1:0] dvs_mag;
	logic [WORK_W:0]   shifted;
	logic [WORK_W:0]   diff;
	logic [WORK_W-1:0] quo_s;
	logic [WORK_W-1:0] rem_s;

	// magnitudes; the most negative value maps onto its unsigned magnitude
	assign dvd_mag = req.dividend[WORK_W-1] ? (~req.dividend + WORK_W'(1)) : req.dividend;
	assign dvs_mag = req.divisor[WORK_W-1] ? (~req.divisor + WORK_W'(1)) : req.divisor;

	// restoring step
	assign shifted = {rem_q, quo_q[WORK_W-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WORK_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			den_q  <= dvs_mag;
			quo_q  <= dvd_mag;
			rem_q  <= '0;
			qneg_q <= req.dividend[WORK_W-1] ^ req.divisor[WORK_W-1];
			rneg_q <= req.dividend[WORK_W-1];
		end else if (busy_q) begin
			rem_q <= diff[WORK_W] ? shifted[WORK_W-1:0] : diff[WORK_W-1:0];
			quo_q <= {quo_q[WORK_W-2:0], ~diff[WORK_W]};
		end
	end

	// remainder takes the dividend's sign, quotient the xor of both
	assign quo_s = qneg_q ? (~quo_q + WORK_W'(1)) : quo_q;
	assign rem_s = rneg_q ? (~rem_q + WORK_W'(1)) : rem_q;

	assign rsp.done = done_q;
	assign rsp.quot = signed'(quo_s);
	assign rsp.rem  = signed'(rem_s);

endmodule

// ----- hdl/rational_arith_reduce_unit.sv -----
// top level: command sequencer, shared multiplier, euclid loop on the shared divider
`timescale 1ns / 1ps
// sequence: the multiplier states form the raw terms, then each euclid step is one pass
//   on the shared divider, then euclid exit, two reduced-term divider passes and finish;
//   when both raw terms are zero, euclid exit goes straight to finish
// a new word waits until the last has left finish; the divider's loop sets the pace
// input taken only in idle; an output register lets the next word in behind a stalled result
// reset (arst_n low, asynchronous): sequencer back to idle, no result pending
module rational_arith_reduce_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [rar_pkg::CMD_W-1:0]            command,
	input  logic signed [rar_pkg::IN_W-1:0]      a_num,
	input  logic signed [rar_pkg::IN_W-1:0]      a_den,
	input  logic signed [rar_pkg::IN_W-1:0]      b_num,
	input  logic signed [rar_pkg::IN_W-1:0]      b_den,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [rar_pkg::RAW_NUM_W-1:0] raw_num,
	output logic signed [rar_pkg::RAW_DEN_W-1:0] raw_den,
	output logic signed [rar_pkg::RAW_NUM_W-1:0] red_num,
	output logic signed [rar_pkg::RAW_DEN_W-1:0] red_den,
	output logic signed [rar_pkg::RAW_NUM_W-1:0] divisor,
	output logic                                 whole_flag,
	output logic                                 zero_error
);
	import rar_pkg::*;

	state_t state_q, state_d;

	// captured operands
	cmd_t                         cmd_q;
	logic signed [TERM_WIDTH-1:0] an_q, ad_q, bn_q, bd_q;

	// products from the shared multiplier
	logic signed [TERM_WIDTH-1:0] mul_a, mul_b;
	logic signed [PROD_W-1:0]     prod;
	logic signed [PROD_W-1:0]     p_q, q_q, d_q;

	// raw terms and euclid pair
	logic signed [WORK_W-1:0] rn_c, rd_c;
	logic signed [WORK_W-1:0] rn_q, rd_q, x_q, y_q;
	logic signed [WORK_W-1:0] rdn_q, rdd_q;
	logic                     err_q;

	// output register
	logic                        out_valid_q;
	logic                        out_free;
	logic signed [WORK_W-1:0]    raw_num_q, raw_den_q, red_num_q, red_den_q, divisor_q;
	logic                        whole_q, zero_err_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	rar_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// single shared multiplier, registered into p, q or d by state
	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

	assign out_free = !out_valid_q || !out_stall;

	// raw terms from registered products; operands for equal denominators or reciprocal
	always_comb begin
		logic signed [WORK_W-1:0] an_w, ad_w, bn_w, bd_w, p_w, q_w, d_w;
		an_w = WORK_W'(an_q);
		ad_w = WORK_W'(ad_q);
		bn_w = WORK_W'(bn_q);
		bd_w = WORK_W'(bd_q);
		p_w  = WORK_W'(p_q);
		q_w  = WORK_W'(q_q);
		d_w  = WORK_W'(d_q);
		case (cmd_q)
			CMD_ADD: begin
				rn_c = (ad_q == bd_q) ? (an_w + bn_w) : (p_w + q_w);
				rd_c = (ad_q == bd_q) ? bd_w : d_w;
			end
			CMD_SUB: begin
				rn_c = (ad_q == bd_q) ? (an_w - bn_w) : (p_w - q_w);
				rd_c = (ad_q == bd_q) ? bd_w : d_w;
			end
			CMD_MUL, CMD_DIV: begin
				rn_c = p_w;
				rd_c = d_w;
			end
			default: begin
				// reciprocal, and unused codes behave the same
				rn_c = ad_w;
				rd_c = an_w;
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:    if (in_valid) state_d = S_MUL0;
			S_MUL0:    state_d = S_MUL1;
			S_MUL1:    state_d = S_MUL2;
			S_MUL2:    state_d = S_COMB;
			S_COMB:    state_d = S_EUCLID;
			S_EUCLID: begin
				if (y_q != '0) begin
					state_d = S_EU_WAIT;
				end else if (x_q == '0) begin
					state_d = S_FINISH;
				end else begin
					state_d = S_QN;
				end
			end
			S_EU_WAIT: if (div_rsp.done) state_d = S_EUCLID;
			S_QN:      state_d = S_QN_WAIT;
			S_QN_WAIT: if (div_rsp.done) state_d = S_QD;
			S_QD:      state_d = S_QD_WAIT;
			S_QD_WAIT: if (div_rsp.done) state_d = S_FINISH;
			S_FINISH:  if (out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// sequencer outputs: handshake, multiplier operands, divider requests
	always_comb begin
		in_stall         = (state_q != S_IDLE);
		mul_a            = an_q;
		mul_b            = bd_q;
		div_req.start    = 1'b0;
		div_req.dividend = x_q;
		div_req.divisor  = y_q;
		case (state_q)
			S_MUL0: begin
				mul_a = an_q;
				mul_b = (cmd_q == CMD_MUL) ? bn_q : bd_q;
			end
			S_MUL1: begin
				mul_a = bn_q;
				mul_b = ad_q;
			end
			S_MUL2: begin
				mul_a = ad_q;
				mul_b = (cmd_q == CMD_DIV) ? bn_q : bd_q;
			end
			S_EUCLID: begin
				div_req.start = (y_q != '0);
			end
			S_QN: begin
				div_req.start    = 1'b1;
				div_req.dividend = rn_q;
				div_req.divisor  = x_q;
			end
			S_QD: begin
				div_req.start    = 1'b1;
				div_req.dividend = rd_q;
				div_req.divisor  = x_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_q <= cmd_t'(command);
					an_q  <= a_num[TERM_WIDTH-1:0];
					ad_q  <= a_den[TERM_WIDTH-1:0];
					bn_q  <= b_num[TERM_WIDTH-1:0];
					bd_q  <= b_den[TERM_WIDTH-1:0];
				end
			end
			S_MUL0: p_q <= prod;
			S_MUL1: q_q <= prod;
			S_MUL2: d_q <= prod;
			S_COMB: begin
				rn_q <= rn_c;
				rd_q <= rd_c;
				x_q  <= rn_c;
				y_q  <= rd_c;
			end
			S_EUCLID: begin
				// loop exit: zero gcd means both raw terms were zero
				err_q <= (y_q == '0) && (x_q == '0);
				rdn_q <= '0;
				rdd_q <= '0;
			end
			S_EU_WAIT: begin
				if (div_rsp.done) begin
					x_q <= y_q;
					y_q <= div_rsp.rem;
				end
			end
			S_QN_WAIT: if (div_rsp.done) rdn_q <= div_rsp.quot;
			S_QD_WAIT: if (div_rsp.done) rdd_q <= div_rsp.quot;
			default: begin
			end
		endcase

		if (state_q == S_FINISH && out_free) begin
			raw_num_q  <= rn_q;
			raw_den_q  <= rd_q;
			red_num_q  <= rdn_q;
			red_den_q  <= rdd_q;
			divisor_q  <= x_q;
			whole_q    <= !err_q && (rd_q == x_q);
			zero_err_q <= err_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign raw_num    = RAW_NUM_W'(raw_num_q);
	assign raw_den    = RAW_DEN_W'(raw_den_q);
	assign red_num    = RAW_NUM_W'(red_num_q);
	assign red_den    = RAW_DEN_W'(red_den_q);
	assign divisor    = RAW_NUM_W'(divisor_q);
	assign whole_flag = whole_q;
	assign zero_error = zero_err_q;

	// a new result only ever appears out of the finish state
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_FINISH))
		else $error("result raised outside finish state");

	// an accepted word always starts the product sequence
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_MUL0))
		else $error("accepted word did not start the sequencer");

	// error results carry zero reduced terms and divisor
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && zero_error) |-> (red_num == '0 && red_den == '0 && divisor == '0
			&& !whole_flag))
		else $error("zero divisor result not cleared");

	// a whole result reduces its denominator to one
	a_whole_one: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && whole_flag) |-> (red_den == RAW_DEN_W'(1)))
		else $error("whole result with reduced denominator not one");

endmodule
